// ===== sv/mtps_pkg.sv =====
package mtps_pkg;

  localparam int CODE_MAX = 15;
  localparam int REM_W    = 4;

  localparam logic [1:0] SYM_END   = 2'b00;
  localparam logic [1:0] SYM_DASH  = 2'b01;
  localparam logic [1:0] SYM_DOT   = 2'b10;
  localparam logic [1:0] SYM_SPACE = 2'b11;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_LOW_A  = 8'h61;
  localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [REM_W-1:0] UNKNOWN_LEN = REM_W'(8);

  // one symbol handed from the sequencer to the packer
  typedef struct packed {
    logic [1:0]       code;
    logic [REM_W-1:0] rem;    // symbols of this transaction still to come
    logic             flush;
  } sym_t;

  // dash map left-aligned: bit CODE_MAX-1 is the first element
  typedef struct packed {
    logic [REM_W-1:0]    len;  // 0 = not in table
    logic [CODE_MAX-1:0] dash;
  } code_t;

  function automatic code_t mk(input logic [REM_W-1:0] len, input logic [CODE_MAX-1:0] raw);
    code_t r;
    r.len  = len;
    r.dash = raw << (CODE_MAX - int'(len));
    return r;
  endfunction

  function automatic code_t lookup(input logic [7:0] key);
    code_t r;
    case (key)
      8'h41: r = mk(4'd2, 15'b01);
      8'h42: r = mk(4'd4, 15'b1000);
      8'h43: r = mk(4'd4, 15'b1010);
      8'h44: r = mk(4'd3, 15'b100);
      8'h45: r = mk(4'd1, 15'b0);
      8'h46: r = mk(4'd4, 15'b0010);
      8'h47: r = mk(4'd3, 15'b110);
      8'h48: r = mk(4'd4, 15'b0000);
      8'h49: r = mk(4'd2, 15'b00);
      8'h4a: r = mk(4'd4, 15'b0111);
      8'h4b: r = mk(4'd3, 15'b101);
      8'h4c: r = mk(4'd4, 15'b0100);
      8'h4d: r = mk(4'd2, 15'b11);
      8'h4e: r = mk(4'd2, 15'b10);
      8'h4f: r = mk(4'd3, 15'b111);
      8'h50: r = mk(4'd4, 15'b0110);
      8'h51: r = mk(4'd4, 15'b1101);
      8'h52: r = mk(4'd3, 15'b010);
      8'h53: r = mk(4'd3, 15'b000);
      8'h54: r = mk(4'd1, 15'b1);
      8'h55: r = mk(4'd3, 15'b001);
      8'h56: r = mk(4'd4, 15'b0001);
      8'h57: r = mk(4'd3, 15'b011);
      8'h58: r = mk(4'd4, 15'b1001);
      8'h59: r = mk(4'd4, 15'b1011);
      8'h5a: r = mk(4'd4, 15'b1100);
      8'h30: r = mk(4'd5, 15'b11111);
      8'h31: r = mk(4'd5, 15'b01111);
      8'h32: r = mk(4'd5, 15'b00111);
      8'h33: r = mk(4'd5, 15'b00011);
      8'h34: r = mk(4'd5, 15'b00001);
      8'h35: r = mk(4'd5, 15'b00000);
      8'h36: r = mk(4'd5, 15'b10000);
      8'h37: r = mk(4'd5, 15'b11000);
      8'h38: r = mk(4'd5, 15'b11100);
      8'h39: r = mk(4'd5, 15'b11110);
      8'h25: r = mk(4'd15, 15'b111111001011111);
      8'h26: r = mk(4'd5, 15'b01000);
      8'h27: r = mk(4'd6, 15'b011110);
      8'h40: r = mk(4'd6, 15'b011010);
      8'h29: r = mk(4'd6, 15'b101101);
      8'h28: r = mk(4'd5, 15'b10110);
      8'h3a: r = mk(4'd6, 15'b111000);
      8'h2c: r = mk(4'd6, 15'b110011);
      8'h3d: r = mk(4'd5, 15'b10001);
      8'h21: r = mk(4'd6, 15'b101011);
      8'h2e: r = mk(4'd6, 15'b010101);
      8'h2d: r = mk(4'd6, 15'b100001);
      8'h2b: r = mk(4'd5, 15'b01010);
      8'h22: r = mk(4'd6, 15'b010010);
      8'h3f: r = mk(4'd6, 15'b001100);
      8'h2f: r = mk(4'd5, 15'b10010);
      8'h0a: r = mk(4'd4, 15'b0101);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/morse_text_to_packed_symbols.sv =====
// Channel  Handshake             Payload
// in       in_valid / in_stall   req_type, char_code
// out      out_valid / out_stall out_byte, last_of_run, message_end
//
// A character is sequenced as n symbols, where n is its code length plus
// a terminator (up to 16); a space is one symbol, a flush two. The symbol
// sequencer emits one 2-bit symbol per cycle into the byte packer unless out_stall pauses it.
// in_stall is high while a transaction is being sequenced; out_stall holds
// the output register while out_valid is high and pauses the sequencer. rst
// (synchronous) empties the packer and idles the sequencer.
module morse_text_to_packed_symbols (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       message_end
);
  import mtps_pkg::*;

  sym_t sym;
  logic sym_valid;
  logic sym_ready;

  mtps_symgen u_symgen (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .char_code (char_code),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym)
  );

  mtps_packer u_packer (
    .clk         (clk),
    .rst         (rst),
    .sym_valid   (sym_valid),
    .sym_ready   (sym_ready),
    .sym         (sym),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .message_end (message_end)
  );

endmodule

// ===== sv/mtps_symgen.sv =====
module mtps_symgen (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [7:0]         char_code,
  output logic               sym_valid,
  input  logic               sym_ready,
  output mtps_pkg::sym_t     sym
);
  import mtps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_TEXT  = 4'b0010,
    S_SPACE = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t              state;
  logic [CODE_MAX-1:0] pat;
  logic [REM_W-1:0]    rem;
  logic [7:0]          key;
  code_t               code;
  logic                push;

  always_comb begin
    key = char_code;
    if (char_code inside {[CHAR_LOW_A:CHAR_LOW_Z]}) begin
      key = char_code - CASE_OFFSET;
    end
    code = lookup(key);
  end

  assign in_stall  = (state != S_IDLE);
  assign sym_valid = (state != S_IDLE);
  assign push      = sym_valid && sym_ready;

  always_comb begin
    sym.rem   = rem;
    sym.flush = (state == S_FLUSH);
    case (state)
      S_TEXT:  sym.code = (rem == '0) ? SYM_END : (pat[CODE_MAX-1] ? SYM_DASH : SYM_DOT);
      S_SPACE: sym.code = SYM_SPACE;
      default: sym.code = SYM_END;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rem   <= '0;
      pat   <= '0;
    end else if (state == S_IDLE) begin
      if (in_valid) begin
        if (req_type) begin
          state <= S_FLUSH;
          rem   <= REM_W'(1);
        end else if (code.len != '0) begin
          state <= S_TEXT;
          rem   <= code.len;
          pat   <= code.dash;
        end else if (char_code == CHAR_SPACE) begin
          state <= S_SPACE;
          rem   <= '0;
        end else begin
          state <= S_TEXT;
          rem   <= UNKNOWN_LEN;
          pat   <= '0;
        end
      end
    end else if (push) begin
      if (rem == '0) begin
        state <= S_IDLE;
      end else begin
        rem <= rem - REM_W'(1);
        pat <= {pat[CODE_MAX-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== sv/mtps_packer.sv =====
module mtps_packer (
  input  logic               clk,
  input  logic               rst,
  input  logic               sym_valid,
  output logic               sym_ready,
  input  mtps_pkg::sym_t     sym,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               last_of_run,
  output logic               message_end
);
  import mtps_pkg::*;

  logic [7:0] pending;
  logic [1:0] count;
  logic [7:0] shifted;
  logic       push;
  logic       emit;

  assign sym_ready = !out_valid || !out_stall;
  assign push      = sym_valid && sym_ready;
  assign shifted   = {pending[5:0], sym.code};
  // flush's final symbol always sends out whatever is pending, full or not
  assign emit      = (count == 2'd3) || (sym.flush && (sym.rem == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (push) begin
        if (emit) begin
          pending   <= '0;
          count     <= '0;
          out_valid <= 1'b1;
        end else begin
          pending <= shifted;
          count   <= count + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && emit) begin
      out_byte    <= shifted;
      // for text, another byte follows only if at least four symbols remain; a flush's final symbol ends the run
      last_of_run <= sym.flush ? (sym.rem == '0) : (sym.rem < REM_W'(4));
      message_end <= sym.flush;
    end
  end

endmodule
